/* rtl/sidlfp_pkg.sv */
package sidlfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ErrW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [ByteW-1:0] FirstSyncReset  = 8'd170;
  localparam logic [ByteW-1:0] SecondSyncReset = 8'd85;

  localparam logic [CfgIdxW-1:0] CfgFirstSync  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondSync = 8'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_GOOD    = 2'd2,
    EV_ERROR   = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_ID    = 3'd3,
    PH_BODY  = 3'd4,
    PH_SUM   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] first_sync;
    logic [ByteW-1:0] second_sync;
  } cfg_t;

  typedef struct packed {
    event_e              kind;
    logic [ByteW-1:0]    out_byte;
    logic [ByteW-1:0]    frame_id;
    logic [ByteW-1:0]    frame_length;
    logic [ByteW-1:0]    position;
    logic [ErrW-1:0]     error_total;
    logic [CountW-1:0]   bytes_seen;
  } res_t;

endpackage

/* rtl/sidlfp_cfg.sv */
module sidlfp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [sidlfp_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [sidlfp_pkg::ByteW-1:0]  wr_data_i,
  output sidlfp_pkg::cfg_t              cfg_o
);
  import sidlfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CfgFirstSync:  cfg_d.first_sync  = wr_data_i;
        CfgSecondSync: cfg_d.second_sync = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sync  <= FirstSyncReset;
      cfg_q.second_sync <= SecondSyncReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/sidlfp_step.sv */
module sidlfp_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sidlfp_pkg::cfg_t             cfg_i,
  input  logic                         adv_i,
  input  logic [sidlfp_pkg::ByteW-1:0] byte_i,
  output sidlfp_pkg::res_t             res_o
);
  import sidlfp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   id_q, id_d;
  logic [ByteW-1:0]   len_q, len_d;
  logic [ByteW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]   sum_q, sum_d;
  logic [ErrW-1:0]    err_q, err_d;
  logic [CountW-1:0]  seen_q, seen_d;
  logic               fail;

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    err_d   = err_q;
    seen_d  = seen_q + CountW'(1);
    fail    = 1'b0;
    res_o.kind     = EV_NONE;
    res_o.out_byte = '0;
    res_o.position = '0;
    case (phase_q)
      PH_SYNC1: begin
        if (byte_i == cfg_i.second_sync) begin
          phase_d = PH_SYNC2;
          sum_d   = '0;
        end else begin
          fail = 1'b1;
        end
      end
      PH_SYNC2: begin
        id_d    = byte_i;
        sum_d   = sum_q + byte_i;
        phase_d = PH_ID;
      end
      PH_ID: begin
        len_d   = byte_i;
        sum_d   = sum_q + byte_i;
        cnt_d   = '0;
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        res_o.kind     = EV_PAYLOAD;
        res_o.out_byte = byte_i;
        res_o.position = cnt_q;
        sum_d          = sum_q + byte_i;
        cnt_d          = cnt_q + ByteW'(1);
        if (cnt_d >= len_q) begin
          phase_d = PH_SUM;
        end
      end
      PH_SUM: begin
        if (byte_i == sum_q) begin
          res_o.kind = EV_GOOD;
          phase_d    = PH_HUNT;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        phase_d = (byte_i == cfg_i.first_sync) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
    if (fail) begin
      res_o.kind = EV_ERROR;
      err_d      = err_q + ErrW'(1);
      phase_d    = PH_HUNT;
    end
    res_o.frame_id     = id_d;
    res_o.frame_length = len_d;
    res_o.error_total  = err_d;
    res_o.bytes_seen   = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      id_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      err_q   <= '0;
      seen_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      err_q   <= err_d;
      seen_q  <= seen_d;
    end
  end

endmodule

/* rtl/sync_id_length_sum_frame_parser.sv */
// Channel  | Direction | Contents
// ---------+-----------+------------------------------------------------------
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tuser[1:0] event_kind; tdata packed result fields
// cfg      | in        | cfg_index_i 0 first_sync, 1 second_sync; cfg_data_i
//
// One word per cycle sustained while results are taken, input register to result
// register. The parser state updates as a word moves from the input register
// to the result register. Reset returns to hunting with sync values 170 and 85.
// A stalled result holds; a word is still taken while the input register is
// empty or drains into the result register in the same cycle.
module sync_id_length_sum_frame_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [79:0]                    m_axis_tdata,   // [7:0] out_byte,
                                                         // [15:8] frame_id,
                                                         // [23:16] frame_length,
                                                         // [31:24] payload_position,
                                                         // [47:32] error_total,
                                                         // [79:48] bytes_seen
  output logic [1:0]                     m_axis_tuser,   // [1:0] event_kind
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sidlfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import sidlfp_pkg::*;

  cfg_t             cfg;
  res_t             res_d, res_q;
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic             adv;
  logic             take_in;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = take_in || (in_valid_q && !adv);
  assign out_valid_d   = adv || (out_valid_q && !m_axis_tready);

  sidlfp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  sidlfp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {res_q.bytes_seen, res_q.error_total, res_q.position,
                          res_q.frame_length, res_q.frame_id, res_q.out_byte};

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind != EV_PAYLOAD) |->
      (res_q.out_byte == '0) && (res_q.position == '0))
    else $error("payload fields set on a non-payload result");

  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result register not loaded after advance");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q))
    else $error("input word lost while stalled");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && adv |=> res_q.bytes_seen == $past(res_q.bytes_seen) + 32'd1)
    else $error("byte count did not advance by one");

endmodule

/* dv/tb_sync_id_length_sum_frame_parser.sv */
`timescale 1ns / 100ps

module tb_sync_id_length_sum_frame_parser;
  import sidlfp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 40;
  localparam logic [CfgIdxW-1:0] CfgUnusedLow  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHigh = 8'hFF;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [7:0]         cfg_data_i    = '0;

  sync_id_length_sum_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // expected parser state
  logic [7:0]  sync_first  = FirstSyncReset;
  logic [7:0]  sync_second = SecondSyncReset;
  phase_e      parse_phase = PH_HUNT;
  logic [7:0]  cur_id      = '0;
  logic [7:0]  cur_len     = '0;
  logic [7:0]  body_count  = '0;
  logic [7:0]  run_sum     = '0;
  logic [15:0] err_count   = '0;
  logic [31:0] seen_bytes  = '0;

  res_t        pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_request = 0;
  bit          source_gaps = 1'b0;
  bit          sink_stalls = 1'b0;

  function automatic res_t predict_result(input logic [7:0] b);
    res_t r;
    logic bad;
    r = '0;
    r.kind = EV_NONE;
    bad = 1'b0;
    seen_bytes++;
    case (parse_phase)
      PH_SYNC1: begin
        if (b == sync_second) begin
          parse_phase = PH_SYNC2;
          run_sum = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SYNC2: begin
        cur_id = b;
        run_sum += b;
        parse_phase = PH_ID;
      end
      PH_ID: begin
        cur_len = b;
        run_sum += b;
        body_count = '0;
        parse_phase = PH_BODY;
      end
      PH_BODY: begin
        r.kind = EV_PAYLOAD;
        r.out_byte = b;
        r.position = body_count;
        run_sum += b;
        body_count++;
        if (body_count >= cur_len) parse_phase = PH_SUM;
      end
      PH_SUM: begin
        if (b == run_sum) begin
          r.kind = EV_GOOD;
          parse_phase = PH_HUNT;
        end else begin
          bad = 1'b1;
        end
      end
      default: parse_phase = (b == sync_first) ? PH_SYNC1 : PH_HUNT;
    endcase
    if (bad) begin
      r.kind = EV_ERROR;
      err_count++;
      parse_phase = PH_HUNT;
    end
    r.frame_id     = cur_id;
    r.frame_length = cur_len;
    r.error_total  = err_count;
    r.bytes_seen   = seen_bytes;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 5));
    if (r < 98) return 8'($urandom_range(6, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("ERROR result %0d: %s", results_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_error("result word with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("event_kind", 32'(m_axis_tuser), 32'(want.kind));
          check_field("out_byte", 32'(m_axis_tdata[7:0]), 32'(want.out_byte));
          check_field("frame_id", 32'(m_axis_tdata[15:8]), 32'(want.frame_id));
          check_field("frame_length", 32'(m_axis_tdata[23:16]), 32'(want.frame_length));
          check_field("payload_position", 32'(m_axis_tdata[31:24]), 32'(want.position));
          check_field("error_total", 32'(m_axis_tdata[47:32]), 32'(want.error_total));
          check_field("bytes_seen", m_axis_tdata[79:48], want.bytes_seen);
        end
        results_checked++;
      end
      if (s_axis_tvalid && s_axis_tready) pending_results.push_back(predict_result(s_axis_tdata));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgFirstSync:  sync_first  = cfg_data_i;
          CfgSecondSync: sync_second = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("sync_id_length_sum_frame_parser test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] fill, input bit random_fill,
                            input bit bad_sum);
    logic [7:0]  check_sum;
    logic [7:0]  b;
    int unsigned n;
    n = (len == 0) ? 1 : len;
    check_sum = id + len;
    send_byte(sync_first);
    send_byte(sync_second);
    send_byte(id);
    send_byte(len);
    repeat (n) begin
      b = random_fill ? 8'($urandom) : fill;
      check_sum += b;
      send_byte(b);
    end
    if (bad_sum) check_sum ^= 8'(1 << $urandom_range(0, 7));
    send_byte(check_sum);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_frame(8'($urandom), pick_length(), '0, 1'b1, 1'b0);
      end else if (pick < 74) begin
        send_frame(8'($urandom), pick_length(), '0, 1'b1, 1'b1);
      end else if (pick < 82) begin
        send_byte(sync_first);
        send_byte(sync_second ^ 8'($urandom_range(1, 255)));
      end else if (pick < 88) begin
        // cut the frame short; the next frame lands in its payload
        k = $urandom_range(2, 20);
        send_byte(sync_first);
        send_byte(sync_second);
        send_byte(8'($urandom));
        send_byte(8'(k));
        repeat ($urandom_range(0, k - 1)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_directed_cases();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    // wrong second sync, not taken as a new first sync
    send_byte(sync_first);
    send_byte(sync_first);
    send_frame(8'h00, 8'h02, 8'hFF, 1'b0, 1'b0);
    send_frame(8'h7F, 8'h01, 8'h80, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_input_stall();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_request = 60;
    send_frame(8'($urandom), 8'd30, '0, 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_sync_registers();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_reg(CfgFirstSync, 8'h00);
    write_reg(CfgSecondSync, 8'hFF);
    send_traffic(60);
    write_reg(CfgFirstSync, 8'hFF);
    write_reg(CfgSecondSync, 8'h00);
    send_traffic(60);
    write_reg(CfgUnusedLow, 8'h33);
    write_reg(CfgUnusedHigh, 8'hCC);
    send_traffic(60);
    write_reg(CfgFirstSync, 8'h5A);
    write_reg(CfgSecondSync, 8'h5A);
    send_traffic(60);
    write_reg(CfgFirstSync, 8'($urandom));
    write_reg(CfgSecondSync, 8'($urandom));
    send_traffic(60);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input bit src_idle,
                                     input bit sink_idle);
    source_gaps = src_idle;
    sink_stalls = sink_idle;
    send_traffic(n_bytes);
    drain_results();
  endtask

  task automatic test_sync_errors();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    // back-to-back bad second sync bytes
    repeat (12) begin
      send_byte(sync_first);
      send_byte(sync_second ^ 8'h01);
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_input_stall();
    test_sync_registers();
    test_random_traffic(270, 1'b1, 1'b1);
    test_random_traffic(270, 1'b0, 1'b0);
    test_random_traffic(270, 1'b1, 1'b0);
    test_random_traffic(270, 1'b0, 1'b1);
    test_sync_errors();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sync_id_length_sum_frame_parser test passed");
    end else begin
      $display("sync_id_length_sum_frame_parser test failed");
    end
    $finish;
  end

endmodule

/* sync_id_length_sum_frame_parser.f */
rtl/sidlfp_pkg.sv
rtl/sidlfp_cfg.sv
rtl/sidlfp_step.sv
rtl/sync_id_length_sum_frame_parser.sv
dv/tb_sync_id_length_sum_frame_parser.sv
